### src/quoted_delimiter_tokenizer_macros.svh
// Assertion macros used by the checker file of the tokenizer.
`ifndef QUOTED_DELIMITER_TOKENIZER_MACROS_SVH
`define QUOTED_DELIMITER_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QDT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QDT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/qdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdt_pkg
// Shared types, constants and helpers of the quoted delimiter tokenizer.
// ----------------------------------------------------------------------------
package qdt_pkg;

    localparam int DELIM_LANES   = 4;   // byte lanes of the delimiter register
    localparam int MAX_DELIM_DEF = 4;
    localparam int OPQ_DEPTH     = 4;

    localparam logic [7:0]  QUOTE_CHAR      = 8'h22;
    localparam logic [31:0] DELIM_BYTES_RST = 32'h0000_0020;
    localparam logic [2:0]  DELIM_LEN_RST   = 3'd1;
    localparam logic [15:0] COUNT_MAX       = 16'h7FFF;

    typedef enum logic {
        CFG_DELIM_BYTES = 1'b0,
        CFG_DELIM_LEN   = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_CONTENT,
        OP_DELIM,
        OP_ITEM_END,
        OP_END
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] data;
    } op_t;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               byte_valid;
        logic               token_end;
        logic               discard;
        logic               status_valid;
        logic signed [15:0] count;
    } result_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_SCAN,
        FR_FLUSH
    } front_state_t;

    typedef enum logic {
        BK_RUN,
        BK_REPLAY
    } back_state_t;

    function automatic result_t content_result(input logic [7:0] b);
        result_t r;
        r            = '0;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        return r;
    endfunction

endpackage

### src/qdt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdt_front
// Accepts string bytes, runs the delimiter matcher over the held bytes and
// issues content, delimiter and end operations to the op queue.
// ----------------------------------------------------------------------------
module qdt_front import qdt_pkg::*; #(
    parameter int MAX_DELIM = MAX_DELIM_DEF,
    localparam int LMAX = (MAX_DELIM < DELIM_LANES) ? MAX_DELIM : DELIM_LANES,
    localparam int NW   = $clog2(LMAX + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_data_byte,
    input  logic          s_byte_present,
    input  logic          s_end_of_string,
    input  logic [31:0]   delim_bytes,
    input  logic [NW-1:0] delim_len,
    output logic          op_valid,
    input  logic          op_ready,
    output op_t           op_data
);

    front_state_t  state_reg, state_next;
    logic [7:0]    p_reg [LMAX];
    logic [7:0]    p_next [LMAX];
    logic [7:0]    p_sh1 [LMAX];
    logic [7:0]    p_shl [LMAX];
    logic [NW-1:0] n_reg, n_next;
    logic          eos_reg;
    logic [NW-1:0] m;
    logic          eq, partial, full;
    logic          sh_one, sh_len, finish, go_flush;
    logic          push, finish_now, accept;

    // prefix compare against the delimiter
    always_comb begin
        m  = (n_reg < delim_len) ? n_reg : delim_len;
        eq = 1'b1;
        for (int i = 0; i < LMAX; i++) begin
            if (i < int'(m) && p_reg[i] != delim_bytes[8*i +: 8]) eq = 1'b0;
        end
        partial = eq && (n_reg < delim_len);
        full    = eq && !partial;
    end

    always_comb begin
        for (int i = 0; i < LMAX; i++) begin
            p_sh1[i] = (i + 1 < LMAX) ? p_reg[(i + 1) % LMAX] : p_reg[i];
            p_shl[i] = p_reg[i];
            for (int j = 0; j < LMAX; j++) begin
                if (j - i == int'(delim_len)) p_shl[i] = p_reg[j];
            end
        end
    end

    // outputs
    always_comb begin
        op_valid = 1'b0;
        op_data  = '0;
        sh_one   = 1'b0;
        sh_len   = 1'b0;
        finish   = 1'b0;
        go_flush = 1'b0;
        unique case (state_reg)
            FR_IDLE: begin
            end
            FR_SCAN: begin
                op_valid = 1'b1;
                if (n_reg != '0 && !partial) begin
                    if (full) begin
                        op_data.kind = OP_DELIM;
                        sh_len       = 1'b1;
                    end else begin
                        op_data.kind = OP_CONTENT;
                        op_data.data = p_reg[0];
                        sh_one       = 1'b1;
                    end
                end else if (eos_reg) begin
                    go_flush = 1'b1;
                    if (n_reg != '0) begin
                        op_data.kind = OP_CONTENT;
                        op_data.data = p_reg[0];
                        sh_one       = 1'b1;
                    end else begin
                        op_data.kind = OP_END;
                        finish       = 1'b1;
                    end
                end else begin
                    op_data.kind = OP_ITEM_END;
                    finish       = 1'b1;
                end
            end
            FR_FLUSH: begin
                op_valid = 1'b1;
                if (n_reg != '0) begin
                    op_data.kind = OP_CONTENT;
                    op_data.data = p_reg[0];
                    sh_one       = 1'b1;
                end else begin
                    op_data.kind = OP_END;
                    finish       = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign push       = op_valid && op_ready;
    assign finish_now = push && finish;
    assign s_ready    = (state_reg == FR_IDLE) || finish_now;
    assign accept     = s_valid && s_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FR_IDLE: begin
                if (accept) state_next = FR_SCAN;
            end
            FR_SCAN: begin
                if (finish_now) state_next = accept ? FR_SCAN : FR_IDLE;
                else if (push && go_flush) state_next = FR_FLUSH;
            end
            FR_FLUSH: begin
                if (finish_now) state_next = accept ? FR_SCAN : FR_IDLE;
            end
            default: state_next = FR_IDLE;
        endcase
    end

    // held bytes; a finishing op never shifts, so a load can share its cycle
    always_comb begin
        p_next = p_reg;
        n_next = n_reg;
        if (push && sh_one) begin
            p_next = p_sh1;
            n_next = n_reg - NW'(1);
        end else if (push && sh_len) begin
            p_next = p_shl;
            n_next = n_reg - delim_len;
        end
        if (accept && s_byte_present) begin
            for (int i = 0; i < LMAX; i++) begin
                if (int'(n_reg) == i) p_next[i] = s_data_byte;
            end
            n_next = n_reg + NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
            n_reg     <= '0;
            eos_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
            if (accept) eos_reg <= s_end_of_string;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg <= p_next;
    end

endmodule

### src/qdt_opq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdt_opq
// Small FIFO of operations between the matcher and the token engine.
// ----------------------------------------------------------------------------
module qdt_opq import qdt_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  op_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output op_t  out_data
);

    localparam int PW = $clog2(OPQ_DEPTH);
    localparam int CW = $clog2(OPQ_DEPTH + 1);

    op_t           mem [OPQ_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          wr, rd;

    assign in_ready  = count_reg != CW'(OPQ_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem[rd_ptr_reg];
    assign wr        = in_valid && in_ready;
    assign rd        = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr) wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (rd) rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (wr && !rd) count_reg <= count_reg + CW'(1);
            else if (rd && !wr) count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) mem[wr_ptr_reg] <= in_data;
    end

endmodule

### src/qdt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdt_back
// Token engine: tracks segment, quote and count state, expands operations
// into results and marks the last result of each transaction.
// ----------------------------------------------------------------------------
module qdt_back import qdt_pkg::*; #(
    parameter int MAX_DELIM = MAX_DELIM_DEF,
    localparam int LMAX = (MAX_DELIM < DELIM_LANES) ? MAX_DELIM : DELIM_LANES,
    localparam int NW   = $clog2(LMAX + 1),
    localparam int IW   = (LMAX > 1) ? $clog2(LMAX) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               op_valid,
    output logic               op_ready,
    input  op_t                op_data,
    input  logic [31:0]        delim_bytes,
    input  logic [NW-1:0]      delim_len,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_out_byte_valid,
    output logic               m_token_end,
    output logic               m_token_discard,
    output logic               m_status_valid,
    output logic signed [15:0] m_result_count,
    output logic               m_last
);

    back_state_t state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;

    logic        seg_ne_reg, seg_ne_next;
    logic        tok_ne_reg, tok_ne_next;
    logic        first_q_reg, first_q_next;
    logic [7:0]  prev_reg, prev_next;
    logic        quote_open_reg, quote_open_next;
    logic [15:0] count_reg, count_next, count_inc;

    result_t     gen;
    logic        gen_valid, gen_last, step_active, item_end;
    logic        delim_close, enter_replay, is_content, is_delim, is_end;
    logic [7:0]  replay_byte, content_byte;
    logic        needs_pend, fire, out_free, release_pend;

    result_t     pend_reg, out_reg;
    logic        pend_valid_reg, pend_last_reg;
    logic        m_valid_reg, out_last_reg;

    assign count_inc    = (count_reg < COUNT_MAX) ? count_reg + 16'd1 : count_reg;
    assign replay_byte  = delim_bytes[{idx_reg, 3'b000} +: 8];
    assign content_byte = (state_reg == BK_REPLAY) ? replay_byte : op_data.data;

    // outputs
    always_comb begin
        gen          = '0;
        gen_valid    = 1'b0;
        gen_last     = 1'b0;
        step_active  = 1'b0;
        item_end     = 1'b0;
        delim_close  = 1'b0;
        enter_replay = 1'b0;
        is_content   = 1'b0;
        is_delim     = 1'b0;
        is_end       = 1'b0;
        unique case (state_reg)
            BK_RUN: begin
                if (op_valid) begin
                    step_active = 1'b1;
                    unique case (op_data.kind)
                        OP_CONTENT: begin
                            is_content = 1'b1;
                            gen        = content_result(content_byte);
                            gen_valid  = 1'b1;
                        end
                        OP_DELIM: begin
                            is_delim = 1'b1;
                            // a finished segment closes unless it is an unterminated quote
                            if (seg_ne_reg && (!first_q_reg || prev_reg == QUOTE_CHAR)) begin
                                gen.token_end = 1'b1;
                                gen_valid     = 1'b1;
                                delim_close   = 1'b1;
                            end else if (quote_open_reg || seg_ne_reg) begin
                                enter_replay = 1'b1;
                            end
                        end
                        OP_ITEM_END: begin
                            item_end = 1'b1;
                        end
                        OP_END: begin
                            is_end           = 1'b1;
                            gen_valid        = 1'b1;
                            gen_last         = 1'b1;
                            gen.status_valid = 1'b1;
                            if (seg_ne_reg) begin
                                gen.token_end = 1'b1;
                                gen.count     = $signed(count_inc);
                            end else if (tok_ne_reg) begin
                                gen.discard = 1'b1;
                                gen.count   = $signed(count_reg);
                            end else begin
                                gen.token_end = 1'b1;
                                gen.count     = 16'sd1 - $signed(count_reg);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BK_REPLAY: begin
                step_active = 1'b1;
                is_content  = 1'b1;
                gen         = content_result(content_byte);
                gen_valid   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // a new result or an item boundary needs the holding slot to move on
    assign out_free     = !m_valid_reg || m_ready;
    assign needs_pend   = gen_valid || item_end;
    assign fire         = step_active && (!needs_pend || !pend_valid_reg || out_free);
    assign op_ready     = fire && (state_reg == BK_RUN);
    assign release_pend = pend_valid_reg && out_free && (pend_last_reg || (fire && needs_pend));

    // next state
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            BK_RUN: begin
                if (fire && enter_replay) begin
                    state_next = BK_REPLAY;
                    idx_next   = '0;
                end
            end
            BK_REPLAY: begin
                if (fire) begin
                    if (int'(idx_reg) == int'(delim_len) - 1) state_next = BK_RUN;
                    else idx_next = idx_reg + IW'(1);
                end
            end
            default: state_next = BK_RUN;
        endcase
    end

    // token state
    always_comb begin
        seg_ne_next     = seg_ne_reg;
        tok_ne_next     = tok_ne_reg;
        first_q_next    = first_q_reg;
        prev_next       = prev_reg;
        quote_open_next = quote_open_reg;
        count_next      = count_reg;
        if (fire) begin
            if (is_content) begin
                if (!tok_ne_reg) first_q_next = (content_byte == QUOTE_CHAR);
                tok_ne_next = 1'b1;
                prev_next   = content_byte;
                if (state_reg == BK_RUN) seg_ne_next = 1'b1;
            end else if (delim_close) begin
                seg_ne_next     = 1'b0;
                tok_ne_next     = 1'b0;
                first_q_next    = 1'b0;
                prev_next       = '0;
                quote_open_next = 1'b0;
                count_next      = count_inc;
            end else if (is_delim) begin
                seg_ne_next     = 1'b0;
                quote_open_next = quote_open_reg || seg_ne_reg;
            end else if (is_end) begin
                seg_ne_next     = 1'b0;
                tok_ne_next     = 1'b0;
                first_q_next    = 1'b0;
                prev_next       = '0;
                quote_open_next = 1'b0;
                count_next      = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_RUN;
            idx_reg        <= '0;
            seg_ne_reg     <= 1'b0;
            tok_ne_reg     <= 1'b0;
            first_q_reg    <= 1'b0;
            prev_reg       <= '0;
            quote_open_reg <= 1'b0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            seg_ne_reg     <= seg_ne_next;
            tok_ne_reg     <= tok_ne_next;
            first_q_reg    <= first_q_next;
            prev_reg       <= prev_next;
            quote_open_reg <= quote_open_next;
            count_reg      <= count_next;
            if (fire && gen_valid) begin
                pend_valid_reg <= 1'b1;
                pend_last_reg  <= gen_last;
            end else if (release_pend) begin
                pend_valid_reg <= 1'b0;
                pend_last_reg  <= 1'b0;
            end
            if (release_pend) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && gen_valid) pend_reg <= gen;
        if (release_pend) begin
            out_reg      <= pend_reg;
            out_last_reg <= pend_last_reg || (fire && item_end);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_byte       = out_reg.out_byte;
    assign m_out_byte_valid = out_reg.byte_valid;
    assign m_token_end      = out_reg.token_end;
    assign m_token_discard  = out_reg.discard;
    assign m_status_valid   = out_reg.status_valid;
    assign m_result_count   = out_reg.count;
    assign m_last           = out_last_reg;

endmodule

### src/quoted_delimiter_tokenizer.sv
`timescale 1ns / 1ps
// Results pass the held bytes, op queue, holding slot and output register in order.
// The op queue drains one operation per cycle unless a replay or output stall holds it;
// a byte giving one result needs a content op and an item-end op; a delimiter in an open
// quoted token replays delimiter_length bytes. End of string adds one op per held byte.
// Reset (synchronous, aresetn low): string state, queue and outputs cleared;
// delimiter_bytes = 0x20, delimiter_length = 1.
// ----------------------------------------------------------------------------
// quoted_delimiter_tokenizer
// Splits a byte stream on a multi-byte delimiter, honoring quoted tokens.
// ----------------------------------------------------------------------------
module quoted_delimiter_tokenizer import qdt_pkg::*; #(
    parameter int MAX_DELIM = MAX_DELIM_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [0:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_byte_present,
    input  logic               s_end_of_string,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_out_byte_valid,
    output logic               m_token_end,
    output logic               m_token_discard,
    output logic               m_status_valid,
    output logic signed [15:0] m_result_count,
    output logic               m_last
);

    localparam int LMAX = (MAX_DELIM < DELIM_LANES) ? MAX_DELIM : DELIM_LANES;
    localparam int NW   = $clog2(LMAX + 1);

    logic [31:0]   delim_bytes_reg;
    logic [2:0]    delim_len_reg;
    logic [NW-1:0] delim_len_eff;

    logic fq_valid, fq_ready, bq_valid, bq_ready;
    op_t  fq_data, bq_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_bytes_reg <= DELIM_BYTES_RST;
            delim_len_reg   <= DELIM_LEN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DELIM_BYTES: delim_bytes_reg <= cfg_wdata;
                CFG_DELIM_LEN:   delim_len_reg   <= cfg_wdata[2:0];
                default: begin
                end
            endcase
        end
    end

    // zero acts as one, anything past the supported length is clamped
    always_comb begin
        if (delim_len_reg == 3'd0) delim_len_eff = NW'(1);
        else if (int'(delim_len_reg) > LMAX) delim_len_eff = NW'(LMAX);
        else delim_len_eff = NW'(delim_len_reg);
    end

    qdt_front #(.MAX_DELIM(MAX_DELIM)) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_byte_present  (s_byte_present),
        .s_end_of_string (s_end_of_string),
        .delim_bytes     (delim_bytes_reg),
        .delim_len       (delim_len_eff),
        .op_valid        (fq_valid),
        .op_ready        (fq_ready),
        .op_data         (fq_data)
    );

    qdt_opq u_opq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_data  (bq_data)
    );

    qdt_back #(.MAX_DELIM(MAX_DELIM)) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .op_valid         (bq_valid),
        .op_ready         (bq_ready),
        .op_data          (bq_data),
        .delim_bytes      (delim_bytes_reg),
        .delim_len        (delim_len_eff),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_out_byte_valid (m_out_byte_valid),
        .m_token_end      (m_token_end),
        .m_token_discard  (m_token_discard),
        .m_status_valid   (m_status_valid),
        .m_result_count   (m_result_count),
        .m_last           (m_last)
    );

endmodule

### src/qdt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qdt_checker
// Port-level checks on the result channel of the tokenizer.
// ----------------------------------------------------------------------------
`include "quoted_delimiter_tokenizer_macros.svh"

module qdt_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [7:0]         m_out_byte,
    input logic               m_out_byte_valid,
    input logic               m_token_end,
    input logic               m_token_discard,
    input logic               m_status_valid,
    input logic signed [15:0] m_result_count,
    input logic               m_last
);

    `QDT_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_byte) && $stable(m_result_count) && $stable(m_last), "result changed while stalled")
    `QDT_ASSERT_IMP(a_byte_zero, aclk, aresetn, m_valid && !m_out_byte_valid, m_out_byte == 8'h00, "out_byte nonzero without a token byte")
    `QDT_ASSERT_IMP(a_count_zero, aclk, aresetn, m_valid && !m_status_valid, m_result_count == 16'sd0, "result_count nonzero without status")
    `QDT_ASSERT_IMP(a_status_last, aclk, aresetn, m_valid && m_status_valid, m_last, "status result not marked last")
    `QDT_ASSERT_IMP(a_byte_alone, aclk, aresetn, m_valid && m_out_byte_valid, !m_token_end && !m_token_discard && !m_status_valid, "token byte carries other flags")

endmodule

bind quoted_delimiter_tokenizer qdt_checker u_qdt_checker (.*);
